// ===== hdl/text_line_justifier_defines.svh =====
// Assertion macros shared by the justifier RTL.
`ifndef TEXT_LINE_JUSTIFIER_DEFINES_SVH
`define TEXT_LINE_JUSTIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLJ_ASSERT_IMPL(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TLJ_ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/tlj_pkg.sv =====
`timescale 1ns / 1ps
package tlj_pkg;
	localparam int MAX_WIDTH = 32;
	localparam int MAX_WORDS = 16;
	localparam logic [7:0] SPACE_CHAR = 8'd32;
	localparam logic [5:0] WIDTH_RESET = 6'd32;
	localparam logic [2:0] REG_LINE_WIDTH_ADDR = 3'd0;
	localparam int DIV_STEPS = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_PLACE
	} tlj_state_t;
endpackage

// ===== hdl/text_line_justifier.sv =====
`timescale 1ns / 1ps
// channel   | kind          | word contents
// ----------+---------------+---------------------------------------------
// s_axis    | stream in     | tdata char_code, tlast word_end, tuser text_end
// m_axis    | stream out    | tdata out_char, tlast line_end, tuser text_done
// apb       | register port | line_width at byte address 0
//
// A character that does not end a word is taken in ST_IDLE. A word end copies the
// word onto the held line in ST_PLACE; a line flush emits one output character per
// position of the effective width in ST_EMIT, after the restoring divider in ST_DIV
// (DIV_STEPS steps) when the line is justified. Output stalls hold the flush.
// Reset (arst_n, asynchronous) clears line state; character stores are not reset.
module text_line_justifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  logic       s_axis_tlast,   // word_end
	input  logic       s_axis_tuser,   // [0] text_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic       m_axis_tlast,   // line_end
	output logic       m_axis_tuser,   // [0] text_done
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import tlj_pkg::*;
	`include "text_line_justifier_defines.svh"

	tlj_state_t state_q, state_nx;

	logic [5:0] line_width_q;
	logic [7:0] line_q [MAX_WIDTH];
	logic [7:0] pend_q [MAX_WIDTH];
	logic [5:0] len_q  [MAX_WORDS];
	logic [4:0] count_q;
	logic [5:0] used_q;
	logic [5:0] letters_q;
	logic [5:0] pl_q;
	logic       final_q;
	logic       tail_q;    // line being emitted is the last of the text

	// divider
	logic [5:0] rem_q, quo_q, div_q;
	logic [2:0] step_q;
	logic [5:0] avg_q, extra_q;
	logic       just_q;

	// line walker
	logic [5:0] pos_q, ci_q, src_q, gap_q, cp_q;
	logic [4:0] wi_q;

	logic       m_valid_q, m_last_q, m_user_q;
	logic [7:0] m_data_q;

	// effective width and decode
	logic [5:0] w_eff;
	logic       in_acc, add_ch, ends_word, go_flush, justify;
	logic [5:0] pl_new;
	logic [6:0] fit_sum;
	logic       emit_load, div_step, place_step, emit_last, place_last, div_last;
	logic       in_word;
	logic [7:0] cur_ch;
	logic [5:0] gval, r_shift;
	logic [6:0] store_idx;

	always_comb begin
		if (line_width_q == 6'd0) w_eff = 6'd1;
		else if (line_width_q > 6'(MAX_WIDTH)) w_eff = 6'(MAX_WIDTH);
		else w_eff = line_width_q;
	end

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign add_ch    = pl_q < w_eff;
	assign pl_new    = pl_q + (add_ch ? 6'd1 : 6'd0);
	assign ends_word = s_axis_tlast || s_axis_tuser;
	assign fit_sum   = {1'b0, used_q} + 7'd1 + {1'b0, pl_new};
	assign go_flush  = (count_q != 5'd0) &&
		((count_q >= 5'(MAX_WORDS)) || (fit_sum > {1'b0, w_eff}));
	assign justify   = (count_q >= 5'd2) && (used_q <= w_eff) && (letters_q < w_eff);

	assign in_word  = (gap_q == 6'd0) && (wi_q < count_q);
	assign cur_ch   = in_word ? line_q[src_q[4:0]] : SPACE_CHAR;
	assign gval     = just_q ? (avg_q + (({1'b0, wi_q} < extra_q) ? 6'd1 : 6'd0)) : 6'd1;
	assign r_shift  = {rem_q[4:0], quo_q[5]};
	assign store_idx = {1'b0, letters_q} + {1'b0, cp_q};

	assign emit_last  = pos_q == (w_eff - 6'd1);
	assign place_last = (cp_q + 6'd1) >= pl_q;
	assign div_last   = step_q == 3'(DIV_STEPS - 1);

	// sequencer outputs
	always_comb begin
		s_axis_tready = state_q == ST_IDLE;
		emit_load     = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
		div_step      = state_q == ST_DIV;
		place_step    = state_q == ST_PLACE;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && ends_word) begin
					if (go_flush) state_nx = justify ? ST_DIV : ST_EMIT;
					else state_nx = ST_PLACE;
				end
			end
			ST_DIV: begin
				if (div_last) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_load && emit_last) state_nx = tail_q ? ST_IDLE : ST_PLACE;
			end
			ST_PLACE: begin
				if (place_last) state_nx = final_q ? ST_EMIT : ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			line_width_q <= WIDTH_RESET;
			count_q      <= '0;
			used_q       <= '0;
			letters_q    <= '0;
			pl_q         <= '0;
			final_q      <= 1'b0;
			tail_q       <= 1'b0;
			just_q       <= 1'b0;
			step_q       <= '0;
			pos_q        <= '0;
			ci_q         <= '0;
			src_q        <= '0;
			gap_q        <= '0;
			wi_q         <= '0;
			cp_q         <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (psel && penable && pwrite && pready && paddr == REG_LINE_WIDTH_ADDR)
				line_width_q <= pwdata[5:0];

			if (emit_load) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;

			// take a character
			if (in_acc) begin
				pl_q <= pl_new;
				if (ends_word) begin
					final_q <= s_axis_tuser;
					tail_q  <= 1'b0;
					just_q  <= justify;
					step_q  <= '0;
					cp_q    <= '0;
					pos_q   <= '0;
					ci_q    <= '0;
					src_q   <= '0;
					gap_q   <= '0;
					wi_q    <= '0;
				end
			end

			if (div_step) step_q <= step_q + 3'd1;

			// walk the held line, one character per output word
			if (emit_load) begin
				pos_q     <= pos_q + 6'd1;
				if (gap_q != 6'd0) begin
					gap_q <= gap_q - 6'd1;
				end else if (in_word) begin
					src_q <= src_q + 6'd1;
					if (ci_q + 6'd1 == len_q[wi_q[3:0]]) begin
						ci_q  <= '0;
						wi_q  <= wi_q + 5'd1;
						gap_q <= ((wi_q + 5'd1) < count_q) ? gval : 6'd0;
					end else begin
						ci_q <= ci_q + 6'd1;
					end
				end
				if (emit_last) begin
					count_q   <= '0;
					used_q    <= '0;
					letters_q <= '0;
					cp_q      <= '0;
				end
			end

			// copy the finished word onto the held line
			if (place_step) begin
				cp_q <= cp_q + 6'd1;
				if (place_last) begin
					if (count_q < 5'(MAX_WORDS)) count_q <= count_q + 5'd1;
					used_q    <= used_q + ((count_q != 5'd0) ? 6'd1 : 6'd0) + pl_q;
					letters_q <= letters_q + pl_q;
					pl_q      <= '0;
					tail_q    <= final_q;
					just_q    <= 1'b0;
					pos_q     <= '0;
					ci_q      <= '0;
					src_q     <= '0;
					gap_q     <= '0;
					wi_q      <= '0;
				end
			end
		end
	end

	// character stores and data path, no reset
	always_ff @(posedge clk) begin
		if (in_acc && add_ch) pend_q[pl_q[4:0]] <= s_axis_tdata;

		if (in_acc && ends_word) begin
			rem_q <= '0;
			quo_q <= w_eff - letters_q;
			div_q <= {1'b0, (count_q - 5'd1)};
		end
		if (div_step) begin
			if (r_shift >= div_q) begin
				rem_q <= r_shift - div_q;
				quo_q <= {quo_q[4:0], 1'b1};
			end else begin
				rem_q <= r_shift;
				quo_q <= {quo_q[4:0], 1'b0};
			end
			if (div_last) begin
				avg_q   <= {quo_q[4:0], (r_shift >= div_q)};
				extra_q <= (r_shift >= div_q) ? (r_shift - div_q) : r_shift;
			end
		end

		if (place_step) begin
			if (store_idx < 7'(MAX_WIDTH)) line_q[store_idx[4:0]] <= pend_q[cp_q[4:0]];
			if (place_last && count_q < 5'(MAX_WORDS)) len_q[count_q[3:0]] <= pl_q;
		end

		if (emit_load) begin
			m_data_q <= cur_ch;
			m_last_q <= emit_last;
			m_user_q <= emit_last && tail_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;
	assign pready        = 1'b1;
	assign prdata        = (paddr == REG_LINE_WIDTH_ADDR) ? {26'd0, line_width_q} : 32'd0;

	`TLJ_ASSERT_IMPL(a_done_on_line_end, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`TLJ_ASSERT_IMPL(a_ready_only_idle, clk, arst_n, s_axis_tready, state_q == ST_IDLE)
	`TLJ_ASSERT_IMPL(a_div_nonzero, clk, arst_n, state_q == ST_DIV, div_q != 6'd0)
	`TLJ_ASSERT_IMPL(a_pend_bound, clk, arst_n, 1'b1, pl_q <= 6'(MAX_WIDTH))
endmodule

// ===== dv/tb_text_line_justifier.sv =====
`timescale 1ns / 1ps
module tb_text_line_justifier;
	import tlj_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [7:0] char_code;
		logic       word_end;
		logic       text_end;
	} char_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       line_end;
		logic       text_done;
	} line_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] char_code
	logic        s_axis_tlast = 1'b0; // word_end
	logic        s_axis_tuser = 1'b0; // [0] text_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [7:0] out_char
	logic        m_axis_tlast;        // line_end
	logic        m_axis_tuser;        // [0] text_done
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	text_line_justifier u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [5:0]  pm_width;
	logic [7:0]  pm_line[MAX_WIDTH];
	int unsigned pm_lens[MAX_WORDS];
	int unsigned pm_count, pm_used;
	logic [7:0]  pm_pend[MAX_WIDTH];
	int unsigned pm_pend_len;

	char_word_t  char_queue[$];
	line_char_t  expected_chars[$];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          errors = 0;
	int          idle_cycles = 0;

	// append one input word to the pending queue
	task automatic enqueue_char(input char_word_t it);
		char_queue = {char_queue, it};
	endtask

	function automatic int unsigned eff_width();
		if (pm_width == 0) return 1;
		if (pm_width > MAX_WIDTH) return MAX_WIDTH;
		return pm_width;
	endfunction

	// build one output line and queue its characters
	task automatic queue_line(input bit last_line);
		logic [7:0]  buf_c[MAX_WIDTH];
		int unsigned w, letters, pos, src, avg, extra, spare, gaps;
		bit          justify;
		line_char_t  r;
		w = eff_width();
		letters = 0; pos = 0; src = 0; avg = 1; extra = 0;
		for (int k = 0; k < MAX_WIDTH; k++) buf_c[k] = SPACE_CHAR;
		for (int k = 0; k < pm_count && k < MAX_WORDS; k++) letters += pm_lens[k];
		justify = !last_line && pm_count >= 2 && pm_used <= w && letters < w;
		if (justify) begin
			spare = w - letters;
			gaps = pm_count - 1;
			avg = spare / gaps;
			extra = spare % gaps;
		end
		for (int k = 0; k < pm_count && k < MAX_WORDS; k++) begin
			for (int c = 0; c < pm_lens[k]; c++) begin
				if (pos < w && src < MAX_WIDTH) buf_c[pos] = pm_line[src];
				pos++;
				src++;
			end
			if (k + 1 < pm_count) pos += justify ? avg + ((k < extra) ? 1 : 0) : 1;
		end
		for (int k = 0; k < w; k++) begin
			r.out_char  = buf_c[k];
			r.line_end  = (k + 1 == w);
			r.text_done = last_line && (k + 1 == w);
			expected_chars = {expected_chars, r};
		end
		pm_count = 0;
		pm_used = 0;
	endtask

	task automatic predict_char(input char_word_t it);
		int unsigned w, base;
		w = eff_width();
		if (pm_pend_len < w) begin
			pm_pend[pm_pend_len] = it.char_code;
			pm_pend_len++;
		end
		if (it.word_end || it.text_end) begin
			if (pm_count > 0 && (pm_count >= MAX_WORDS || pm_used + 1 + pm_pend_len > w))
				queue_line(1'b0);
			base = 0;
			for (int k = 0; k < pm_count && k < MAX_WORDS; k++) base += pm_lens[k];
			for (int k = 0; k < pm_pend_len; k++)
				if (base + k < MAX_WIDTH) pm_line[base + k] = pm_pend[k];
			if (pm_count < MAX_WORDS) begin
				pm_lens[pm_count] = pm_pend_len;
				pm_count++;
			end
			pm_used += ((pm_count > 1) ? 1 : 0) + pm_pend_len;
			pm_pend_len = 0;
			if (it.text_end) queue_line(1'b1);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) predict_char(
			char_word_t'{s_axis_tdata, s_axis_tlast, s_axis_tuser});
		if (!s_axis_tvalid || s_axis_tready) begin
			if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= char_queue[0].char_code;
				s_axis_tlast  <= char_queue[0].word_end;
				s_axis_tuser  <= char_queue[0].text_end;
				void'(char_queue.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor and watchdog
	always @(posedge clk) begin
		line_char_t got, exp_c;
		if (m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
			end else begin
				exp_c = expected_chars.pop_front();
				if (got.out_char !== exp_c.out_char)
					$display("%0t: out_char exp %h got %h", $time, exp_c.out_char, got.out_char);
				if (got.line_end !== exp_c.line_end)
					$display("%0t: line_end exp %b got %b", $time, exp_c.line_end, got.line_end);
				if (got.text_done !== exp_c.text_done)
					$display("%0t: text_done exp %b got %b", $time, exp_c.text_done,
						got.text_done);
				if (got !== exp_c) errors++;
			end
		end
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || psel)
			idle_cycles <= 0;
		else if (char_queue.size() > 0 || s_axis_tvalid || expected_chars.size() > 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_width(input logic [5:0] w);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_LINE_WIDTH_ADDR; pwdata <= {26'd0, w};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		pm_width = w;
	endtask

	task automatic add_word(input int len, input bit last_word);
		char_word_t it;
		for (int i = 0; i < len; i++) begin
			it.char_code = $urandom_range(255);
			it.word_end  = (i == len - 1) && ($urandom_range(9) != 0 || !last_word);
			it.text_end  = last_word && (i == len - 1);
			enqueue_char(it);
		end
	endtask

	task automatic add_text(input int words, input int max_len);
		for (int k = 0; k < words; k++) add_word($urandom_range(1, max_len), k == words - 1);
	endtask

	task automatic drain();
		wait (char_queue.size() == 0 && !s_axis_tvalid && expected_chars.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned ew;
		char_word_t  it;
		pm_width = WIDTH_RESET;
		pm_count = 0; pm_used = 0; pm_pend_len = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset width, extreme codes, spaces as data, text end without word end
		enqueue_char(char_word_t'{8'h00, 1'b1, 1'b0});
		enqueue_char(char_word_t'{8'hFF, 1'b1, 1'b0});
		enqueue_char(char_word_t'{SPACE_CHAR, 1'b1, 1'b0});
		enqueue_char(char_word_t'{8'hA5, 1'b0, 1'b0});
		enqueue_char(char_word_t'{8'h5A, 1'b0, 1'b1});
		drain();
		// width zero acts as one, overlong words are cut
		write_width(6'd0);
		enqueue_char(char_word_t'{8'h41, 1'b0, 1'b0});
		enqueue_char(char_word_t'{8'h42, 1'b1, 1'b0});
		enqueue_char(char_word_t'{8'h43, 1'b1, 1'b1});
		drain();
		// width above the maximum, then word limit with one-letter words
		write_width(6'd63);
		for (int i = 0; i < 18; i++) enqueue_char(char_word_t'{8'(i + 97), 1'b1, i == 17});
		drain();
		// width shrunk under a held line
		write_width(6'd20);
		add_word(8, 0); add_word(8, 0);
		drain();
		write_width(6'd5);
		add_word(3, 1);
		drain();

		// random phases over several widths and idling patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			case (ph)
				0: write_width(6'd1);
				1: write_width(6'd32);
				7: write_width(6'($urandom_range(33, 63)));
				default: write_width(6'($urandom_range(2, 32)));
			endcase
			ew = eff_width();
			while (char_queue.size() < 16) begin
				if ($urandom_range(9) == 0) begin
					it.char_code = $urandom_range(255);
					it.word_end = $urandom_range(1);
					it.text_end = $urandom_range(1);
					enqueue_char(it);
				end else begin
					add_text($urandom_range(1, 8), (ew > 2 && $urandom_range(3) != 0) ?
						ew / 2 + 1 : ew + 2);
				end
			end
			if (!char_queue[$].text_end) char_queue[$].text_end = 1'b1;
			drain();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
